@@ rtl/jhmi_pkg.sv @@
// ----------------------------------------------------------------------------
// jhmi_pkg
// Shared constants, types and helpers of the joint-histogram mutual
// information block.
// ----------------------------------------------------------------------------
package jhmi_pkg;

  localparam int BINS_PER_AXIS = 64;
  localparam int BIN_BITS      = $clog2(BINS_PER_AXIS);
  localparam int CELL_BITS     = 2 * BIN_BITS;
  localparam int CELLS         = BINS_PER_AXIS * BINS_PER_AXIS;
  localparam int PIXEL_BITS    = 8;
  localparam int COUNT_BITS    = 24;
  localparam int MI_BITS       = 32;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Logarithm format: integer part of log2 and LOG_FRAC fraction bits.
  localparam int LOG_FRAC      = 26;
  localparam int LOG_INT_BITS  = $clog2(COUNT_BITS);
  localparam int LOG_BITS      = LOG_INT_BITS + LOG_FRAC;
  localparam int LOG_SUM_BITS  = LOG_BITS + 1;
  localparam int MANT_BITS     = 32;
  localparam int PROD_BITS     = COUNT_BITS + LOG_SUM_BITS;
  localparam int ACC_BITS      = 64;

  // Final scaling: quotient carries 8 extra fraction bits.
  localparam int QEXT_BITS     = 8;
  localparam int DIV_BITS      = ACC_BITS + QEXT_BITS;
  localparam int Q2_BITS       = MI_BITS + QEXT_BITS;
  localparam int Q2_HALF       = Q2_BITS / 2;
  localparam int LN2_BITS      = 24;
  localparam logic [LN2_BITS-1:0] LN2_Q24 = 24'd11629080;
  localparam int SCALE_BITS    = Q2_HALF + LN2_BITS;
  localparam int SCALE_SHIFT   = 34;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_INCR,
    S_MARG,
    S_LOGN_GO,
    S_LOGN_WAIT,
    S_MI_RD,
    S_MI_LAT,
    S_LC_GO,
    S_LC_WAIT,
    S_LX_GO,
    S_LX_WAIT,
    S_LY_GO,
    S_LY_WAIT,
    S_MUL,
    S_ACC,
    S_NEXT,
    S_DIV_GO,
    S_DIV_WAIT,
    S_SCALE_LO,
    S_SCALE_HI,
    S_SCALE_SUM,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    LG_IDLE,
    LG_NORM,
    LG_SQR
  } log_phase_t;

  // Bin of a grey value: the top bits of the pixel.
  function automatic logic [BIN_BITS-1:0] to_bin(input logic [PIXEL_BITS-1:0] px);
    return px[PIXEL_BITS-1 -: BIN_BITS];
  endfunction

endpackage

@@ rtl/jhmi_if.sv @@
// ----------------------------------------------------------------------------
// jhmi_if
// Valid/ready channels for pixel pair requests and result requests.
// ----------------------------------------------------------------------------
interface jhmi_pair_if;
  logic                                valid;
  logic                                ready;
  logic [jhmi_pkg::PIXEL_BITS-1:0]     pixel_a;
  logic [jhmi_pkg::PIXEL_BITS-1:0]     pixel_b;
  logic                                last;

  modport source (output valid, pixel_a, pixel_b, last, input ready);
  modport sink   (input valid, pixel_a, pixel_b, last, output ready);
endinterface

interface jhmi_result_if;
  logic                                valid;
  logic                                ready;
  logic [jhmi_pkg::MI_BITS-1:0]        mi_value;
  logic [jhmi_pkg::COUNT_BITS-1:0]     pair_count;
  logic                                overflow;

  modport source (output valid, mi_value, pair_count, overflow, input ready);
  modport sink   (input valid, mi_value, pair_count, overflow, output ready);
endinterface

@@ rtl/jhmi_ram.sv @@
// ----------------------------------------------------------------------------
// jhmi_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module jhmi_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/jhmi_log2.sv @@
// ----------------------------------------------------------------------------
// jhmi_log2
// Iterative fixed-point log2 of a count: normalize one bit a cycle, then one
// mantissa squaring a cycle for each fraction bit.
// ----------------------------------------------------------------------------
module jhmi_log2 (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [jhmi_pkg::COUNT_BITS-1:0] x,
  output logic                            busy,
  output logic                            done,
  output logic [jhmi_pkg::LOG_BITS-1:0]   result
);
  import jhmi_pkg::*;

  localparam int STEP_BITS = $clog2(LOG_FRAC);

  log_phase_t                phase, phase_next;
  logic [MANT_BITS-1:0]      m;
  logic [LOG_INT_BITS-1:0]   e;
  logic [LOG_FRAC-1:0]       frac;
  logic [STEP_BITS-1:0]      step;
  logic [2*MANT_BITS-1:0]    sq;
  logic [MANT_BITS:0]        sq_sh;
  logic [LOG_FRAC-1:0]       frac_next;
  logic                      last_step;

  // Square of the mantissa, truncated to Q2.31.
  assign sq        = m * m;
  assign sq_sh     = sq[2*MANT_BITS-1 -: MANT_BITS+1];
  assign frac_next = {frac[LOG_FRAC-2:0], sq_sh[MANT_BITS]};
  assign last_step = (step == STEP_BITS'(LOG_FRAC - 1));

  // Next phase.
  always_comb begin
    phase_next = phase;
    unique case (phase)
      LG_IDLE: if (start && (x != '0)) phase_next = LG_NORM;
      LG_NORM: if (m[MANT_BITS-1]) phase_next = LG_SQR;
      LG_SQR:  if (last_step) phase_next = LG_IDLE;
      default: phase_next = LG_IDLE;
    endcase
  end

  // Status outputs.
  always_comb begin
    busy = (phase != LG_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= LG_IDLE;
      done  <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= 1'b0;
      unique case (phase)
        LG_IDLE: begin
          if (start) begin
            m    <= {x, (MANT_BITS-COUNT_BITS)'(0)};
            e    <= LOG_INT_BITS'(COUNT_BITS - 1);
            step <= '0;
            if (x == '0) begin
              result <= '0;
              done   <= 1'b1;
            end
          end
        end
        LG_NORM: begin
          if (!m[MANT_BITS-1]) begin
            m <= {m[MANT_BITS-2:0], 1'b0};
            e <= e - 1'b1;
          end
        end
        LG_SQR: begin
          m    <= sq_sh[MANT_BITS] ? sq_sh[MANT_BITS:1] : sq_sh[MANT_BITS-1:0];
          frac <= frac_next;
          step <= step + 1'b1;
          if (last_step) begin
            result <= {e, frac_next};
            done   <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/jhmi_div.sv @@
// ----------------------------------------------------------------------------
// jhmi_div
// Restoring bit-serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module jhmi_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [jhmi_pkg::DIV_BITS-1:0]   dividend,
  input  logic [jhmi_pkg::COUNT_BITS-1:0] divisor,
  output logic                            busy,
  output logic                            done,
  output logic [jhmi_pkg::DIV_BITS-1:0]   quotient
);
  import jhmi_pkg::*;

  localparam int CNT_BITS = $clog2(DIV_BITS);

  logic [CNT_BITS-1:0]   cnt;
  logic [DIV_BITS-1:0]   dvd;
  logic [COUNT_BITS-1:0] dsr;
  logic [COUNT_BITS-1:0] rem;
  logic [COUNT_BITS:0]   trial;
  logic                  fits;

  // Trial subtraction of the divisor from the shifted remainder.
  assign trial = {rem, dvd[DIV_BITS-1]};
  assign fits  = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        if (start) begin
          busy <= 1'b1;
          cnt  <= '0;
          dvd  <= dividend;
          dsr  <= divisor;
          rem  <= '0;
        end
      end else begin
        dvd      <= {dvd[DIV_BITS-2:0], 1'b0};
        rem      <= fits ? COUNT_BITS'(trial - {1'b0, dsr}) : trial[COUNT_BITS-1:0];
        quotient <= {quotient[DIV_BITS-2:0], fits};
        cnt      <= cnt + 1'b1;
        if (cnt == CNT_BITS'(DIV_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/joint_histogram_mutual_information.sv @@
// ----------------------------------------------------------------------------
// joint_histogram_mutual_information
// Counts pixel pairs in a 64x64 joint histogram and reports mutual
// information in nats (unsigned Q8.24) on the last pair of an image.
// ----------------------------------------------------------------------------
// After reset the block clears the histogram memory before it takes the
// first request. Each pixel pair has its histogram cell read, then the
// incremented count written back through the single write port of the
// histogram memory; no new pair is taken before that write-back. On the
// last pair a final pass runs: a sweep over all cells builds the
// marginals, a log2 of the pair count follows, then one cell per visit, an
// empty cell skipped and a filled one taking three runs of the shared log2
// unit and a multiply-add, then bit-serial division (skipped for a zero
// result) and scaling. The histogram is cleared during that pass, so the
// block is ready for the next image as soon as the result is registered;
// the result waits in its output register while new pairs come in.
module joint_histogram_mutual_information (
  input  logic         clk,
  input  logic         rst,
  jhmi_pair_if.sink    pair,
  jhmi_result_if.source result
);
  import jhmi_pkg::*;

  localparam int K_BITS = CELL_BITS + 1;

  state_t                state, state_next;
  logic [K_BITS-1:0]     k;
  logic                  v1;
  logic [CELL_BITS-1:0]  k1;
  logic [COUNT_BITS-1:0] pairs_seen;
  logic                  dropped;
  logic                  cnt_q, last_q;
  logic [CELL_BITS-1:0]  cell_q;
  logic [COUNT_BITS-1:0] rowsum;
  logic [COUNT_BITS-1:0] n_reg, res_count;
  logic                  res_ovf;
  logic [LOG_BITS-1:0]   ln_n;
  logic [COUNT_BITS-1:0] c_q;
  logic [LOG_SUM_BITS-1:0] la, lb;
  logic [PROD_BITS-1:0]  prod;
  logic                  prod_neg;
  logic [ACC_BITS-1:0]   pos, neg;
  logic [Q2_BITS-1:0]    q2;
  logic [SCALE_BITS-1:0] plo, phi;
  logic [MI_BITS-1:0]    mi_q;
  logic                  out_valid;
  logic [MI_BITS-1:0]    out_mi;
  logic [COUNT_BITS-1:0] out_count;
  logic                  out_ovf;

  logic                  pair_fire, out_free;
  logic                  j_we, ma_we, mb_we;
  logic [CELL_BITS-1:0]  j_waddr, j_raddr;
  logic [COUNT_BITS-1:0] j_wdata, j_rd;
  logic [BIN_BITS-1:0]   ma_waddr, ma_raddr, mb_waddr, mb_raddr;
  logic [COUNT_BITS-1:0] ma_wdata, ma_rd, mb_wdata, mb_rd;
  logic                  log_start, log_busy, log_done;
  logic [COUNT_BITS-1:0] log_x;
  logic [LOG_BITS-1:0]   log_res;
  logic                  div_start, div_busy, div_done;
  logic [DIV_BITS-1:0]   div_q;
  logic                  marg_last, mi_last, cell_empty;
  logic [COUNT_BITS-1:0] rs_next;
  logic [LOG_SUM_BITS-1:0] ldiff;
  logic [ACC_BITS:0]     acc_sum;
  logic [ACC_BITS-1:0]   acc_sel;
  logic [ACC_BITS-1:0]   mi_sum;

  assign pair_fire  = pair.valid && pair.ready;
  assign out_free   = !out_valid || result.ready;
  assign marg_last  = v1 && (k1 == CELL_BITS'(CELLS - 1));
  assign mi_last    = (k[CELL_BITS-1:0] == CELL_BITS'(CELLS - 1));
  assign cell_empty = (j_rd == '0) || (ma_rd == '0) || (mb_rd == '0);
  assign rs_next    = ((k1[BIN_BITS-1:0] == '0) ? '0 : rowsum) + j_rd;
  assign ldiff      = (la >= lb) ? (la - lb) : (lb - la);
  assign acc_sel    = prod_neg ? neg : pos;
  assign acc_sum    = {1'b0, acc_sel} + (ACC_BITS+1)'(prod);
  assign mi_sum     = {phi, Q2_HALF'(0)} + ACC_BITS'(plo) + (ACC_BITS'(1) << (SCALE_SHIFT - 1));

  // Memories: joint histogram and the two marginals.
  jhmi_ram #(.WIDTH(COUNT_BITS), .DEPTH(CELLS)) u_joint (
    .clk(clk), .we(j_we), .waddr(j_waddr), .wdata(j_wdata), .raddr(j_raddr), .rdata(j_rd)
  );
  jhmi_ram #(.WIDTH(COUNT_BITS), .DEPTH(BINS_PER_AXIS)) u_marg_a (
    .clk(clk), .we(ma_we), .waddr(ma_waddr), .wdata(ma_wdata), .raddr(ma_raddr), .rdata(ma_rd)
  );
  jhmi_ram #(.WIDTH(COUNT_BITS), .DEPTH(BINS_PER_AXIS)) u_marg_b (
    .clk(clk), .we(mb_we), .waddr(mb_waddr), .wdata(mb_wdata), .raddr(mb_raddr), .rdata(mb_rd)
  );

  // Shared log2 unit and divider.
  jhmi_log2 u_log2 (
    .clk(clk), .rst(rst), .start(log_start), .x(log_x),
    .busy(log_busy), .done(log_done), .result(log_res)
  );
  jhmi_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend({pos - neg, QEXT_BITS'(0)}),
    .divisor(n_reg), .busy(div_busy), .done(div_done), .quotient(div_q)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:     if (mi_last) state_next = S_IDLE;
      S_IDLE:      if (pair_fire) state_next = S_INCR;
      S_INCR:      state_next = last_q ? S_MARG : S_IDLE;
      S_MARG:      if (marg_last) state_next = S_LOGN_GO;
      S_LOGN_GO:   state_next = S_LOGN_WAIT;
      S_LOGN_WAIT: if (log_done) state_next = S_MI_RD;
      S_MI_RD:     state_next = S_MI_LAT;
      S_MI_LAT:    state_next = cell_empty ? S_NEXT : S_LC_GO;
      S_LC_GO:     state_next = S_LC_WAIT;
      S_LC_WAIT:   if (log_done) state_next = S_LX_GO;
      S_LX_GO:     state_next = S_LX_WAIT;
      S_LX_WAIT:   if (log_done) state_next = S_LY_GO;
      S_LY_GO:     state_next = S_LY_WAIT;
      S_LY_WAIT:   if (log_done) state_next = S_MUL;
      S_MUL:       state_next = S_ACC;
      S_ACC:       state_next = S_NEXT;
      S_NEXT:      state_next = mi_last ? S_DIV_GO : S_MI_RD;
      S_DIV_GO:    state_next = (neg >= pos) ? S_DONE : S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_done) begin
          state_next = (div_q[DIV_BITS-1:Q2_BITS] != '0) ? S_DONE : S_SCALE_LO;
        end
      end
      S_SCALE_LO:  state_next = S_SCALE_HI;
      S_SCALE_HI:  state_next = S_SCALE_SUM;
      S_SCALE_SUM: state_next = S_DONE;
      S_DONE:      if (out_free) state_next = S_IDLE;
      default:     state_next = S_CLEAR;
    endcase
  end

  // Memory ports and unit controls.
  always_comb begin
    j_we      = 1'b0;
    j_waddr   = k[CELL_BITS-1:0];
    j_wdata   = '0;
    j_raddr   = k[CELL_BITS-1:0];
    ma_we     = 1'b0;
    ma_waddr  = k1[CELL_BITS-1:BIN_BITS];
    ma_wdata  = rs_next;
    ma_raddr  = k[CELL_BITS-1:BIN_BITS];
    mb_we     = 1'b0;
    mb_waddr  = k1[BIN_BITS-1:0];
    mb_wdata  = ((k1[CELL_BITS-1:BIN_BITS] == '0) ? '0 : mb_rd) + j_rd;
    mb_raddr  = k[BIN_BITS-1:0];
    log_start = 1'b0;
    log_x     = n_reg;
    div_start = 1'b0;
    unique case (state)
      S_CLEAR:  j_we = 1'b1;
      S_IDLE:   j_raddr = {to_bin(pair.pixel_a), to_bin(pair.pixel_b)};
      S_INCR: begin
        j_we    = cnt_q;
        j_waddr = cell_q;
        j_wdata = j_rd + 1'b1;
      end
      S_MARG: begin
        mb_we = v1;
        ma_we = v1 && (k1[BIN_BITS-1:0] == BIN_BITS'(BINS_PER_AXIS - 1));
      end
      S_LOGN_GO: log_start = 1'b1;
      S_MI_LAT:  j_we = 1'b1;
      S_LC_GO: begin
        log_start = 1'b1;
        log_x     = c_q;
      end
      S_LX_GO: begin
        log_start = 1'b1;
        log_x     = ma_rd;
      end
      S_LY_GO: begin
        log_start = 1'b1;
        log_x     = mb_rd;
      end
      S_DIV_GO: div_start = (neg < pos);
      default: ;
    endcase
  end

  // Datapath and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      k          <= '0;
      v1         <= 1'b0;
      pairs_seen <= '0;
      dropped    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      v1    <= 1'b0;
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: k <= mi_last ? '0 : k + 1'b1;
        S_IDLE: begin
          if (pair_fire) begin
            cell_q <= {to_bin(pair.pixel_a), to_bin(pair.pixel_b)};
            last_q <= pair.last;
            cnt_q  <= (pairs_seen != COUNT_MAX);
            if (pairs_seen != COUNT_MAX) begin
              pairs_seen <= pairs_seen + 1'b1;
            end else begin
              dropped <= 1'b1;
            end
          end
        end
        S_INCR: begin
          if (last_q) begin
            n_reg      <= pairs_seen;
            res_count  <= pairs_seen;
            res_ovf    <= dropped;
            pairs_seen <= '0;
            dropped    <= 1'b0;
            k          <= '0;
          end
        end
        S_MARG: begin
          // Issue one cell read a cycle; fold the previous cell into marginals.
          if (!k[CELL_BITS]) begin
            k  <= k + 1'b1;
            v1 <= 1'b1;
            k1 <= k[CELL_BITS-1:0];
          end
          if (v1) begin
            rowsum <= rs_next;
          end
        end
        S_LOGN_WAIT: begin
          if (log_done) begin
            ln_n <= log_res;
            k    <= '0;
            pos  <= '0;
            neg  <= '0;
          end
        end
        S_MI_LAT:  c_q <= j_rd;
        S_LC_WAIT: if (log_done) la <= LOG_SUM_BITS'(log_res) + LOG_SUM_BITS'(ln_n);
        S_LX_WAIT: if (log_done) lb <= LOG_SUM_BITS'(log_res);
        S_LY_WAIT: if (log_done) lb <= lb + LOG_SUM_BITS'(log_res);
        S_MUL: begin
          prod     <= c_q * ldiff;
          prod_neg <= (la < lb);
        end
        S_ACC: begin
          // Saturating add into the positive or negative accumulator.
          if (prod_neg) begin
            neg <= acc_sum[ACC_BITS] ? '1 : acc_sum[ACC_BITS-1:0];
          end else begin
            pos <= acc_sum[ACC_BITS] ? '1 : acc_sum[ACC_BITS-1:0];
          end
        end
        S_NEXT: if (!mi_last) k <= k + 1'b1;
        S_DIV_GO: if (neg >= pos) mi_q <= '0;
        S_DIV_WAIT: begin
          if (div_done) begin
            q2   <= div_q[Q2_BITS-1:0];
            mi_q <= '1;
          end
        end
        S_SCALE_LO:  plo <= SCALE_BITS'(q2[Q2_HALF-1:0]) * SCALE_BITS'(LN2_Q24);
        S_SCALE_HI:  phi <= SCALE_BITS'(q2[Q2_BITS-1:Q2_HALF]) * SCALE_BITS'(LN2_Q24);
        S_SCALE_SUM: mi_q <= MI_BITS'(mi_sum[ACC_BITS-1:SCALE_SHIFT]);
        default: ;
      endcase
    end
  end

  // Result register, loaded when the previous result has been taken.
  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      out_mi    <= mi_q;
      out_count <= res_count;
      out_ovf   <= res_ovf;
    end
  end

  assign pair.ready        = (state == S_IDLE);
  assign result.valid      = out_valid;
  assign result.mi_value   = out_mi;
  assign result.pair_count = out_count;
  assign result.overflow   = out_ovf;

`ifndef SYNTH
  // An accepted pair is always followed by its histogram write-back cycle.
  a_fire_incr: assert property (@(posedge clk) disable iff (rst)
    pair_fire |=> (state == S_INCR))
    else $error("accepted pair not followed by histogram update");

  // The log2 unit is never started while it is still working.
  a_log_start: assert property (@(posedge clk) disable iff (rst)
    log_start |-> !log_busy)
    else $error("log2 unit started while busy");

  // The divider only runs with a nonzero pair count and is not restarted.
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> ((n_reg != '0) && !div_busy))
    else $error("divider started with zero divisor or while busy");

  // A new result only appears from the final state of the pass.
  a_out_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("result raised outside the final state");
`endif

endmodule
